/* design/assert_macros.svh */
// Assertion macros shared by the RTL.
// Depends on signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ETFP_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("etfp assertion failed");

// Next-cycle implication, disabled in reset.
`define ETFP_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("etfp assertion failed");

`endif

/* design/etfp_pkg.sv */
// Shared types, constants and helpers for the escape-time fractal engine.
// No dependencies.
package etfp_pkg;

    localparam int FRAC_BITS   = 26;
    localparam int ADDR_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int ESCAPE_SQ   = 4;

    // register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_ORIGIN_RE  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_IM  = 3'd2;
    localparam logic [2:0] REG_STEP_RE    = 3'd3;
    localparam logic [2:0] REG_STEP_IM    = 3'd4;
    localparam logic [2:0] REG_CONST_RE   = 3'd5;
    localparam logic [2:0] REG_CONST_IM   = 3'd6;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd7;

    // reset values
    localparam logic signed [31:0] RST_ORIGIN_RE = -32'sd134217728;
    localparam logic signed [31:0] RST_ORIGIN_IM = -32'sd100663296;
    localparam logic signed [31:0] RST_STEP_RE   = 32'sd402653;
    localparam logic signed [31:0] RST_STEP_IM   = 32'sd402653;
    localparam logic signed [31:0] RST_CONST_RE  = 32'sd20014533;
    localparam logic signed [31:0] RST_CONST_IM  = -32'sd39876087;
    localparam logic [11:0]        RST_LIMIT     = 12'd1024;

    // color multipliers
    localparam logic [11:0] RED_MUL   = 12'd10;
    localparam logic [11:0] GREEN_MUL = 12'd15;
    localparam logic [11:0] BLUE_MUL  = 12'd3;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
        logic signed [31:0] step_re;
        logic signed [31:0] step_im;
        logic signed [31:0] const_re;
        logic signed [31:0] const_im;
        logic [11:0]        iter_limit;
    } cfg_t;

    // mapped point waiting for the iteration core
    typedef struct packed {
        logic [8:0]         x;
        logic [8:0]         y;
        logic signed [31:0] p_re;
        logic signed [31:0] p_im;
    } point_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } core_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/escape_time_fractal_pixel.sv */
// Escape-time fractal pixel engine: APB registers, front end, queue and iteration core.
// Depends on etfp_pkg, etfp_front, etfp_queue, etfp_core and assert_macros.svh.
// A pixel passes the front register, the queue, the core (cubic mode squares the start
// point first, a zero limit runs no step) and the result register. The core takes a new
// pixel only when idle and sequences each step on its shared 32x32 multiplier.
// Reset (rst_n, async, low) empties queue, loads defaults.
module escape_time_fractal_pixel #(
    parameter int FRACTION_BITS = etfp_pkg::FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [etfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // pixel transactions in
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  logic [8:0]                  pixel_x,
    input  logic [8:0]                  pixel_y,
    // result transactions out
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [8:0]                  out_x,
    output logic [8:0]                  out_y,
    output logic [11:0]                 iterations,
    output logic                        inside_res,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue
);

    `include "assert_macros.svh"

    etfp_pkg::cfg_t        cfg_reg;
    logic [2:0]            reg_idx;
    logic                  wr_en;

    etfp_pkg::point_t      push_data;
    etfp_pkg::point_t      head_data;
    logic                  q_push;
    logic                  q_full;
    logic                  q_not_empty;
    etfp_pkg::core_stat_t  core_stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[etfp_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register file. Writes land on the access phase; values are masked
    // to the register width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= 1'b0;
            cfg_reg.origin_re  <= etfp_pkg::RST_ORIGIN_RE;
            cfg_reg.origin_im  <= etfp_pkg::RST_ORIGIN_IM;
            cfg_reg.step_re    <= etfp_pkg::RST_STEP_RE;
            cfg_reg.step_im    <= etfp_pkg::RST_STEP_IM;
            cfg_reg.const_re   <= etfp_pkg::RST_CONST_RE;
            cfg_reg.const_im   <= etfp_pkg::RST_CONST_IM;
            cfg_reg.iter_limit <= etfp_pkg::RST_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                etfp_pkg::REG_MODE:       cfg_reg.mode       <= pwdata[0];
                etfp_pkg::REG_ORIGIN_RE:  cfg_reg.origin_re  <= pwdata;
                etfp_pkg::REG_ORIGIN_IM:  cfg_reg.origin_im  <= pwdata;
                etfp_pkg::REG_STEP_RE:    cfg_reg.step_re    <= pwdata;
                etfp_pkg::REG_STEP_IM:    cfg_reg.step_im    <= pwdata;
                etfp_pkg::REG_CONST_RE:   cfg_reg.const_re   <= pwdata;
                etfp_pkg::REG_CONST_IM:   cfg_reg.const_im   <= pwdata;
                etfp_pkg::REG_ITER_LIMIT: cfg_reg.iter_limit <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read-back mux, zero extended
    always_comb
    begin
        unique case (reg_idx)
            etfp_pkg::REG_MODE:       prdata = 32'(cfg_reg.mode);
            etfp_pkg::REG_ORIGIN_RE:  prdata = cfg_reg.origin_re;
            etfp_pkg::REG_ORIGIN_IM:  prdata = cfg_reg.origin_im;
            etfp_pkg::REG_STEP_RE:    prdata = cfg_reg.step_re;
            etfp_pkg::REG_STEP_IM:    prdata = cfg_reg.step_im;
            etfp_pkg::REG_CONST_RE:   prdata = cfg_reg.const_re;
            etfp_pkg::REG_CONST_IM:   prdata = cfg_reg.const_im;
            etfp_pkg::REG_ITER_LIMIT: prdata = 32'(cfg_reg.iter_limit);
            default:                  prdata = '0;
        endcase
    end

    // Front end: one stage of index*step products, sum and clamp on push.
    etfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // Decouples pixel intake from the long-running iteration loop.
    etfp_queue #(
        .DEPTH (etfp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (push_data),
        .pop       (core_stat.pop),
        .rdata     (head_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // Back end: iterates one pixel at a time, holds the result until taken.
    etfp_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_not_empty),
        .q_data     (head_data),
        .stat       (core_stat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .iterations (iterations),
        .inside_res (inside_res),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // A point that never escaped is painted black.
    `ETFP_ASSERT_IMP(a_inside_black, res_valid && inside_res, (red | green | blue) == 8'd0)
    // Front end never writes into a full queue.
    `ETFP_ASSERT_IMP(a_no_overrun, q_push, !q_full)
    // Core only takes a point that is there, and is busy right after.
    `ETFP_ASSERT_IMP(a_no_underrun, core_stat.pop, q_not_empty)
    `ETFP_ASSERT_NXT(a_busy_after_pop, core_stat.pop, core_stat.busy)

endmodule

/* design/etfp_front.sv */
// Front end: accepts pixel transactions and maps them to complex points.
// Depends on etfp_pkg.
module etfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  etfp_pkg::cfg_t       cfg,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  logic [8:0]           pixel_x,
    input  logic [8:0]           pixel_y,
    input  logic                 q_full,
    output logic                 q_push,
    output etfp_pkg::point_t     q_data
);

    logic                 v_reg;
    logic [8:0]           x_reg;
    logic [8:0]           y_reg;
    logic signed [41:0]   mre_reg;
    logic signed [41:0]   mim_reg;
    logic                 take;

    assign pix_ready = !v_reg || !q_full;
    assign take      = pix_valid && pix_ready;
    assign q_push    = v_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (take)
        begin
            v_reg <= 1'b1;
        end
        else if (q_push)
        begin
            v_reg <= 1'b0;
        end
    end

    // index * step, exact
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg   <= pixel_x;
            y_reg   <= pixel_y;
            mre_reg <= 42'($signed({1'b0, pixel_x})) * 42'(cfg.step_re);
            mim_reg <= 42'($signed({1'b0, pixel_y})) * 42'(cfg.step_im);
        end
    end

    always_comb
    begin
        q_data.x    = x_reg;
        q_data.y    = y_reg;
        q_data.p_re = etfp_pkg::sat32(64'(cfg.origin_re) + 64'(mre_reg));
        q_data.p_im = etfp_pkg::sat32(64'(cfg.origin_im) + 64'(mim_reg));
    end

endmodule

/* design/etfp_queue.sv */
// Short FIFO of mapped points between front end and iteration core.
// Depends on etfp_pkg.
module etfp_queue #(
    parameter int DEPTH = etfp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  etfp_pkg::point_t  wdata,
    input  logic              pop,
    output etfp_pkg::point_t  rdata,
    output logic              full,
    output logic              not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    etfp_pkg::point_t  mem [DEPTH];
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     rp_reg;
    logic [CW-1:0]     cnt_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= bump(wp_reg);
            end
            if (pop)
            begin
                rp_reg <= bump(rp_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

endmodule

/* design/etfp_core.sv */
// Iteration core: one shared 32x32 multiplier sequenced by a state machine,
// plus the result register. Depends on etfp_pkg.
module etfp_core #(
    parameter int FRACTION_BITS = etfp_pkg::FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  etfp_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  etfp_pkg::point_t      q_data,
    output etfp_pkg::core_stat_t  stat,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [8:0]            out_x,
    output logic [8:0]            out_y,
    output logic [11:0]           iterations,
    output logic                  inside_res,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    localparam logic signed [63:0] BOUND = 64'(etfp_pkg::ESCAPE_SQ) << FRACTION_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_A3   = 4'd1;
    localparam logic [3:0] ST_B3   = 4'd2;
    localparam logic [3:0] ST_XB   = 4'd3;
    localparam logic [3:0] ST_AY   = 4'd4;
    localparam logic [3:0] ST_XY   = 4'd5;
    localparam logic [3:0] ST_HOLD = 4'd6;
    localparam logic [3:0] ST_COMB = 4'd7;
    localparam logic [3:0] ST_SX   = 4'd8;
    localparam logic [3:0] ST_SY   = 4'd9;
    localparam logic [3:0] ST_SQW  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    // product destinations
    localparam logic [2:0] D_A3 = 3'd0;
    localparam logic [2:0] D_B3 = 3'd1;
    localparam logic [2:0] D_XB = 3'd2;
    localparam logic [2:0] D_AY = 3'd3;
    localparam logic [2:0] D_XY = 3'd4;
    localparam logic [2:0] D_SX = 3'd5;
    localparam logic [2:0] D_SY = 3'd6;

    logic [3:0]          st_reg, st_next;
    logic                pend_reg;
    logic                res_valid_reg;
    logic [2:0]          dst_reg;
    logic signed [63:0]  prod_reg;
    logic signed [31:0]  zx_reg, zy_reg, add_re_reg, add_im_reg;
    logic signed [31:0]  a2_reg, b2_reg, a3_reg, b3_reg, xb_reg, ay_reg, xy_reg;
    logic signed [63:0]  wx_reg;
    logic [11:0]         it_reg;
    logic                mode_reg, first_reg, inside_reg;
    logic [8:0]          x_reg, y_reg;

    logic                issue;
    logic [2:0]          dst_c;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  sh_c;
    logic signed [31:0]  sat_c;
    logic signed [63:0]  nx_sum, ny_sum;
    logic                esc;
    logic [11:0]         it_inc;
    logic                slot_free;
    logic                pop;

    assign sh_c      = prod_reg >>> FRACTION_BITS;
    assign sat_c     = etfp_pkg::sat32(sh_c);
    assign esc       = (wx_reg + sh_c) > BOUND;
    assign it_inc    = it_reg + 12'd1;
    assign slot_free = !res_valid_reg || res_ready;
    assign pop       = (st_reg == ST_IDLE) && q_valid;
    assign stat.busy = (st_reg != ST_IDLE);
    assign stat.pop  = pop;
    assign res_valid = res_valid_reg;

    // multiplier operand select
    always_comb
    begin
        issue = 1'b1;
        dst_c = D_A3;
        mul_a = zx_reg;
        mul_b = a2_reg;
        unique case (st_reg)
            ST_A3:
            begin
                dst_c = D_A3;
                mul_a = zx_reg;
                mul_b = a2_reg;
            end
            ST_B3:
            begin
                dst_c = D_B3;
                mul_a = zy_reg;
                mul_b = b2_reg;
            end
            ST_XB:
            begin
                dst_c = D_XB;
                mul_a = zx_reg;
                mul_b = b2_reg;
            end
            ST_AY:
            begin
                dst_c = D_AY;
                mul_a = a2_reg;
                mul_b = zy_reg;
            end
            ST_XY:
            begin
                dst_c = D_XY;
                mul_a = zx_reg;
                mul_b = zy_reg;
            end
            ST_SX:
            begin
                dst_c = D_SX;
                mul_a = zx_reg;
                mul_b = zx_reg;
            end
            ST_SY:
            begin
                dst_c = D_SY;
                mul_a = zy_reg;
                mul_b = zy_reg;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // new z before saturation
    always_comb
    begin
        if (mode_reg)
        begin
            nx_sum = 64'(a2_reg) - 64'(b2_reg) + 64'(add_re_reg);
            ny_sum = (64'(xy_reg) <<< 1) + 64'(add_im_reg);
        end
        else
        begin
            nx_sum = 64'(a3_reg) - ((64'(xb_reg) <<< 1) + 64'(xb_reg))
                   + 64'(a2_reg) - 64'(b2_reg) + (64'(zx_reg) <<< 1)
                   + 64'(add_re_reg);
            ny_sum = (64'(ay_reg) <<< 1) + 64'(ay_reg) - 64'(b3_reg)
                   + (64'(xy_reg) <<< 1) + (64'(zy_reg) <<< 1)
                   + 64'(add_im_reg);
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (cfg.iter_limit == 12'd0)
                    begin
                        st_next = ST_OUT;
                    end
                    else if (cfg.mode)
                    begin
                        st_next = ST_XY;
                    end
                    else
                    begin
                        st_next = ST_SX;
                    end
                end
            end
            ST_A3:   st_next = ST_B3;
            ST_B3:   st_next = ST_XB;
            ST_XB:   st_next = ST_AY;
            ST_AY:   st_next = ST_XY;
            ST_XY:   st_next = ST_HOLD;
            ST_HOLD: st_next = ST_COMB;
            ST_COMB: st_next = ST_SX;
            ST_SX:   st_next = ST_SY;
            ST_SY:   st_next = ST_SQW;
            ST_SQW:
            begin
                if (first_reg)
                begin
                    st_next = ST_A3;
                end
                else if (esc || (it_inc == cfg.iter_limit))
                begin
                    st_next = ST_OUT;
                end
                else if (mode_reg)
                begin
                    st_next = ST_XY;
                end
                else
                begin
                    st_next = ST_A3;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= issue;
            if ((st_reg == ST_OUT) && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        dst_reg  <= dst_c;

        // product write-back from the registered product
        if (pend_reg)
        begin
            case (dst_reg)
                D_A3: a3_reg <= sat_c;
                D_B3: b3_reg <= sat_c;
                D_XB: xb_reg <= sat_c;
                D_AY: ay_reg <= sat_c;
                D_XY: xy_reg <= sat_c;
                D_SX:
                begin
                    a2_reg <= sat_c;
                    wx_reg <= sh_c;
                end
                D_SY: b2_reg <= sat_c;
                default: ;
            endcase
        end

        if (pop)
        begin
            x_reg      <= q_data.x;
            y_reg      <= q_data.y;
            it_reg     <= 12'd0;
            mode_reg   <= cfg.mode;
            first_reg  <= !cfg.mode;
            inside_reg <= 1'b1;
            if (cfg.mode)
            begin
                zx_reg     <= '0;
                zy_reg     <= '0;
                a2_reg     <= '0;
                b2_reg     <= '0;
                add_re_reg <= q_data.p_re;
                add_im_reg <= q_data.p_im;
            end
            else
            begin
                zx_reg     <= q_data.p_re;
                zy_reg     <= q_data.p_im;
                add_re_reg <= cfg.const_re;
                add_im_reg <= cfg.const_im;
            end
        end

        if (st_reg == ST_COMB)
        begin
            zx_reg <= etfp_pkg::sat32(nx_sum);
            zy_reg <= etfp_pkg::sat32(ny_sum);
        end

        if (st_reg == ST_SQW)
        begin
            if (first_reg)
            begin
                first_reg <= 1'b0;
            end
            else if (esc)
            begin
                inside_reg <= 1'b0;
            end
            else
            begin
                it_reg <= it_inc;
            end
        end

        if ((st_reg == ST_OUT) && slot_free)
        begin
            out_x      <= x_reg;
            out_y      <= y_reg;
            iterations <= it_reg;
            inside_res <= inside_reg;
            red        <= inside_reg ? 8'd0 : 8'(it_reg * etfp_pkg::RED_MUL);
            green      <= inside_reg ? 8'd0 : 8'(it_reg * etfp_pkg::GREEN_MUL);
            blue       <= inside_reg ? 8'd0 : 8'(it_reg * etfp_pkg::BLUE_MUL);
        end
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for escape_time_fractal_pixel: pixel transactions in,
// color transactions out, APB register writes between phases.
// Depends on etfp_pkg and the RTL; results are predicted by a fixed-point model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_CUBIC  = 1'b0;
    localparam logic MODE_MANDEL = 1'b1;

    localparam int RANDOM_ITEMS = 580;
    localparam int CALM_TAIL    = 60;   // last random items run with no idling
    localparam int DRAIN_SLACK  = 40;   // cycles watched after the last result
    // The limit covers the slowest legal run (two 4095-step inside points, the
    // reset-limit points, and random phases capped at 255 steps).
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;

    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam longint ESCAPE_BOUND = longint'(etfp_pkg::ESCAPE_SQ) << etfp_pkg::FRAC_BITS;

    // Q6.26 anchors used to build plausible viewing windows
    localparam int Q_ONE  = 67108864;
    localparam int Q_HALF = 33554432;

    // One expected color transaction, at the widths of the result ports.
    typedef struct packed {
        logic [8:0]  x;
        logic [8:0]  y;
        logic [11:0] iters;
        logic        in_set;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_color_t;

    logic                        clk;
    logic                        rst_n   = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [etfp_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        pix_valid = 1'b0;
    logic                        pix_ready;
    logic [8:0]                  pixel_x = '0;
    logic [8:0]                  pixel_y = '0;
    logic                        res_valid;
    logic                        res_ready = 1'b0;
    logic [8:0]                  out_x;
    logic [8:0]                  out_y;
    logic [11:0]                 iterations;
    logic                        inside_res;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;

    // Shadow of the configuration registers, updated on each APB write.
    etfp_pkg::cfg_t model_cfg;

    // Colors still owed by the block, oldest first.
    pixel_color_t pending_colors[$];

    bit calm = 1'b0;    // suppresses idling on both sides

    int mismatches       = 0;
    int results_seen     = 0;
    int inside_seen      = 0;
    int cubic_pixels     = 0;
    int mandel_pixels    = 0;
    int settings_applied = 0;

    escape_time_fractal_pixel u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .iterations (iterations),
        .inside_res (inside_res),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    function automatic longint q_clamp(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    // Rescaled product, floor rounding (arithmetic shift), not clamped.
    function automatic longint q_mul_wide(input longint a, input longint b);
        return (a * b) >>> etfp_pkg::FRAC_BITS;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        return q_clamp(q_mul_wide(a, b));
    endfunction

    // Iterates one pixel under the shadow configuration and returns the
    // escape count and color the block must report for it.
    function automatic pixel_color_t escape_time_of(input logic [8:0] px,
                                                    input logic [8:0] py);
        pixel_color_t r;
        longint       p_re, p_im, zx, zy, add_re, add_im, nx, ny;
        longint       a2, b2, a3, b3;
        int unsigned  n;
        int unsigned  shade;
        bit           escaped;

        p_re = q_clamp(longint'($signed(model_cfg.origin_re))
                       + longint'(px) * longint'($signed(model_cfg.step_re)));
        p_im = q_clamp(longint'($signed(model_cfg.origin_im))
                       + longint'(py) * longint'($signed(model_cfg.step_im)));

        if (model_cfg.mode == MODE_MANDEL)
        begin
            zx     = 0;
            zy     = 0;
            add_re = p_re;
            add_im = p_im;
        end
        else
        begin
            zx     = p_re;
            zy     = p_im;
            add_re = longint'($signed(model_cfg.const_re));
            add_im = longint'($signed(model_cfg.const_im));
        end

        n       = 0;
        escaped = 1'b0;
        while (!escaped && n < model_cfg.iter_limit)
        begin
            if (model_cfg.mode == MODE_MANDEL)
            begin
                nx = q_clamp(q_mul(zx, zx) - q_mul(zy, zy) + add_re);
                ny = q_clamp(2 * q_mul(zx, zy) + add_im);
            end
            else
            begin
                // z^3 + z^2 + 2z + K, every product clamped on its own
                a2 = q_mul(zx, zx);
                b2 = q_mul(zy, zy);
                a3 = q_mul(zx, a2);
                b3 = q_mul(zy, b2);
                nx = q_clamp(a3 - 3 * q_mul(zx, b2) + a2 - b2 + 2 * zx + add_re);
                ny = q_clamp(3 * q_mul(a2, zy) - b3 + 2 * q_mul(zx, zy)
                             + 2 * zy + add_im);
            end
            zx = nx;
            zy = ny;
            // escape test on unclamped squares of the new point
            if (q_mul_wide(zx, zx) + q_mul_wide(zy, zy) > ESCAPE_BOUND)
            begin
                escaped = 1'b1;
            end
            else
            begin
                n++;
            end
        end

        r.x      = px;
        r.y      = py;
        r.iters  = n[11:0];
        r.in_set = !escaped;
        if (escaped)
        begin
            shade   = n * etfp_pkg::RED_MUL;
            r.red   = shade[7:0];
            shade   = n * etfp_pkg::GREEN_MUL;
            r.green = shade[7:0];
            shade   = n * etfp_pkg::BLUE_MUL;
            r.blue  = shade[7:0];
        end
        else
        begin
            r.red   = '0;
            r.green = '0;
            r.blue  = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers (all called at a rising edge, drive with NBAs)
    // ------------------------------------------------------------------

    // APB write: setup cycle, access cycle, then idle, so back-to-back
    // writes never assign psel twice in one step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            etfp_pkg::REG_MODE:       model_cfg.mode       = value[0];
            etfp_pkg::REG_ORIGIN_RE:  model_cfg.origin_re  = value;
            etfp_pkg::REG_ORIGIN_IM:  model_cfg.origin_im  = value;
            etfp_pkg::REG_STEP_RE:    model_cfg.step_re    = value;
            etfp_pkg::REG_STEP_IM:    model_cfg.step_im    = value;
            etfp_pkg::REG_CONST_RE:   model_cfg.const_re   = value;
            etfp_pkg::REG_CONST_IM:   model_cfg.const_im   = value;
            etfp_pkg::REG_ITER_LIMIT: model_cfg.iter_limit = value[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Writes all eight registers; mode and limit words may carry junk above
    // the register width, which the block has to drop.
    task automatic program_window(input logic [31:0] mode_word,
                                  input logic [31:0] org_re, input logic [31:0] org_im,
                                  input logic [31:0] stp_re, input logic [31:0] stp_im,
                                  input logic [31:0] k_re,   input logic [31:0] k_im,
                                  input logic [31:0] limit_word);
        write_reg(etfp_pkg::REG_MODE,       mode_word);
        write_reg(etfp_pkg::REG_ORIGIN_RE,  org_re);
        write_reg(etfp_pkg::REG_ORIGIN_IM,  org_im);
        write_reg(etfp_pkg::REG_STEP_RE,    stp_re);
        write_reg(etfp_pkg::REG_STEP_IM,    stp_im);
        write_reg(etfp_pkg::REG_CONST_RE,   k_re);
        write_reg(etfp_pkg::REG_CONST_IM,   k_im);
        write_reg(etfp_pkg::REG_ITER_LIMIT, limit_word);
        settings_applied++;
    endtask

    // One pixel transaction. Returns at the accepting edge with valid still
    // high; the caller either sends again or drains.
    task automatic push_pixel(input logic [8:0] x, input logic [8:0] y);
        bit took;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel_x   <= x;
        pixel_y   <= y;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = pix_ready;
            @(posedge clk);
        end
        pending_colors.push_back(escape_time_of(x, y));
        if (model_cfg.mode == MODE_MANDEL)
        begin
            mandel_pixels++;
        end
        else
        begin
            cubic_pixels++;
        end
    endtask

    // Drop valid and wait until every owed color has come back; the block
    // is then idle and safe to reprogram.
    task automatic wait_all_results();
        pix_valid <= 1'b0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                begin
                    res_ready <= 1'b1;
                end
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                res_ready <= 1'b0;
                stall_left = $urandom_range(1, 15);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // Handshake is sampled mid-cycle: outputs and ready are stable then and
    // the transaction completes at the following rising edge.
    always @(negedge clk)
    begin : result_check
        pixel_color_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transaction with nothing pending, x=%0d y=%0d",
                         $time, out_x, out_y);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (want.in_set)
                begin
                    inside_seen++;
                end
                compare_field("out_x",      32'(want.x),      32'(out_x));
                compare_field("out_y",      32'(want.y),      32'(out_y));
                compare_field("iterations", 32'(want.iters),  32'(iterations));
                compare_field("inside_res", 32'(want.in_set), 32'(inside_res));
                compare_field("red",        32'(want.red),    32'(red));
                compare_field("green",      32'(want.green),  32'(green));
                compare_field("blue",       32'(want.blue),   32'(blue));
            end
        end
    end

    initial
    begin : watchdog
        longint unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timed out with %0d results outstanding", $time,
                 pending_colors.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power-on registers: cubic mode, limit 1024, default window.
    task automatic test_reset_defaults();
        push_pixel(9'd0,   9'd0);
        push_pixel(9'd511, 9'd511);
        push_pixel(9'd511, 9'd0);
        push_pixel(9'd0,   9'd511);
        push_pixel(9'd170, 9'd256);
        wait_all_results();
    endtask

    // A limit of zero runs no step: count 0, inside, black, in both modes.
    task automatic test_zero_limit();
        program_window({31'd0, MODE_CUBIC}, etfp_pkg::RST_ORIGIN_RE, etfp_pkg::RST_ORIGIN_IM,
                       etfp_pkg::RST_STEP_RE, etfp_pkg::RST_STEP_IM,
                       etfp_pkg::RST_CONST_RE, etfp_pkg::RST_CONST_IM,
                       32'hABCD_E000);
        push_pixel(9'd0,   9'd0);
        push_pixel(9'd511, 9'd511);
        wait_all_results();
        write_reg(etfp_pkg::REG_MODE, {31'd0, MODE_MANDEL});
        push_pixel(9'd256, 9'd256);
        wait_all_results();
    endtask

    // Junk above the register width is dropped on mode and limit.
    task automatic test_register_masking();
        program_window(32'hFFFF_FFFE, etfp_pkg::RST_ORIGIN_RE, etfp_pkg::RST_ORIGIN_IM,
                       etfp_pkg::RST_STEP_RE, etfp_pkg::RST_STEP_IM,
                       etfp_pkg::RST_CONST_RE, etfp_pkg::RST_CONST_IM,
                       32'hFFFF_F005);
        push_pixel(9'd100, 9'd200);
        push_pixel(9'd300, 9'd50);
        wait_all_results();
    endtask

    // Fixed point at zero stays inside for the full 4095 steps in both modes;
    // limit 1 inside, and an escape on the very first step.
    task automatic test_iteration_limits();
        program_window({31'd0, MODE_MANDEL}, '0, '0, '0, '0, '0, '0, 32'd4095);
        push_pixel(9'd511, 9'd511);
        wait_all_results();
        write_reg(etfp_pkg::REG_ITER_LIMIT, 32'd1);
        push_pixel(9'd0, 9'd0);
        wait_all_results();
        program_window({31'd0, MODE_MANDEL}, -3 * Q_ONE, '0, '0, '0, '0, '0, 32'd1);
        push_pixel(9'd7, 9'd9);
        wait_all_results();
        program_window({31'd0, MODE_CUBIC}, '0, '0, '0, '0, '0, '0, 32'd4095);
        push_pixel(9'd511, 9'd0);
        wait_all_results();
    endtask

    // Pixel mapping and the iteration terms pinned at both rails.
    task automatic test_saturation();
        program_window({31'd0, MODE_MANDEL}, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 32'd4095);
        push_pixel(9'd511, 9'd511);
        push_pixel(9'd0,   9'd0);
        push_pixel(9'd1,   9'd1);
        wait_all_results();
        program_window({31'd0, MODE_CUBIC}, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'd4095);
        push_pixel(9'd511, 9'd511);
        push_pixel(9'd0,   9'd0);
        push_pixel(9'd255, 9'd256);
        wait_all_results();
        // moderate start (7.5, -7.5): the cube clamps while z is in range
        program_window({31'd0, MODE_CUBIC}, 15 * Q_HALF, -15 * Q_HALF,
                       '0, '0, '0, '0, 32'd4095);
        push_pixel(9'd3, 9'd3);
        wait_all_results();
    endtask

    // Random windows. Most phases frame the interesting region of the set so
    // escape counts spread out; the rest throw arbitrary 32-bit registers.
    // Limits stay small except in every eighth phase to bound run time.
    task automatic test_random_windows();
        int          done_items;
        int          batch;
        int          kind;
        int          phase;
        logic [31:0] org_re, org_im, stp_re, stp_im, k_re, k_im;
        logic [31:0] mode_word, limit_word;
        logic [8:0]  x, y;

        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            kind          = $urandom_range(0, 9);
            mode_word     = $urandom();
            mode_word[0]  = 1'($urandom_range(0, 1));
            limit_word    = $urandom();
            limit_word[11:0] = (phase % 8 == 3) ? 12'($urandom_range(41, 255))
                                                : 12'($urandom_range(1, 40));
            if (kind < 7)
            begin
                org_re = rand_between(-5 * Q_HALF, -Q_HALF);
                org_im = rand_between(-3 * Q_HALF, -Q_ONE / 5);
                stp_re = rand_between(131072, 458752);
                stp_im = rand_between(131072, 458752);
                k_re   = rand_between(-Q_ONE, Q_ONE);
                k_im   = rand_between(-Q_ONE, Q_ONE);
                if (kind == 6)
                begin
                    // mirrored window, walking with negative steps
                    org_re = -org_re;
                    org_im = -org_im;
                    stp_re = -stp_re;
                    stp_im = -stp_im;
                end
            end
            else
            begin
                org_re = $urandom();
                org_im = $urandom();
                stp_re = $urandom();
                stp_im = $urandom();
                k_re   = $urandom();
                k_im   = $urandom();
            end
            program_window(mode_word, org_re, org_im, stp_re, stp_im, k_re, k_im,
                           limit_word);

            batch = $urandom_range(12, 28);
            if (batch > RANDOM_ITEMS - done_items)
            begin
                batch = RANDOM_ITEMS - done_items;
            end
            calm = (done_items >= RANDOM_ITEMS - CALM_TAIL);
            for (int i = 0; i < batch; i++)
            begin
                x = 9'($urandom_range(0, 511));
                y = 9'($urandom_range(0, 511));
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $urandom_range(0, 1) ? 9'd511 : 9'd0;
                end
                push_pixel(x, y);
            end
            done_items += batch;
            wait_all_results();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        model_cfg.mode       = MODE_CUBIC;
        model_cfg.origin_re  = etfp_pkg::RST_ORIGIN_RE;
        model_cfg.origin_im  = etfp_pkg::RST_ORIGIN_IM;
        model_cfg.step_re    = etfp_pkg::RST_STEP_RE;
        model_cfg.step_im    = etfp_pkg::RST_STEP_IM;
        model_cfg.const_re   = etfp_pkg::RST_CONST_RE;
        model_cfg.const_im   = etfp_pkg::RST_CONST_IM;
        model_cfg.iter_limit = etfp_pkg::RST_LIMIT;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_limit();
        test_register_masking();
        test_iteration_limits();
        test_saturation();
        test_random_windows();

        wait_all_results();
        repeat (DRAIN_SLACK) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, pending_colors.size());
        end

        $display("Checked %0d color transactions (%0d inside) from %0d cubic and %0d",
                 results_seen, inside_seen, cubic_pixels, mandel_pixels);
        $display("Mandelbrot pixels over %0d register settings; %0d mismatches",
                 settings_applied, mismatches);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
